### rtl/csv_order_line_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// csv_order_line_parser_unit_macros.svh
// Assertion macros for the order line parser. They compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef CSV_ORDER_LINE_PARSER_UNIT_MACROS_SVH
`define CSV_ORDER_LINE_PARSER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication on clk, disabled while rst_n is low
`define CSVOP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication on clk, disabled while rst_n is low
`define CSVOP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSVOP_ASSERT_IMP(lbl, ante, cons)
`define CSVOP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/csvop_pkg.sv
// ----------------------------------------------------------------------------
// csvop_pkg
// Codes, keyword constants and helpers for the order line parser.
// ----------------------------------------------------------------------------
`default_nettype none
package csvop_pkg;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FEW       = 3'd1;
  localparam logic [2:0] ST_BAD_NUM   = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_SIDE  = 3'd4;

  localparam logic [1:0] KIND_MARKET = 2'd0;
  localparam logic [1:0] KIND_LIMIT  = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_MODIFY = 2'd3;

  // number phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  // field indexes
  localparam logic [2:0] FLD_ID     = 3'd0;
  localparam logic [2:0] FLD_STAMP  = 3'd1;
  localparam logic [2:0] FLD_TYPE   = 3'd2;
  localparam logic [2:0] FLD_SIDE   = 3'd3;
  localparam logic [2:0] FLD_PRICE  = 3'd4;
  localparam logic [2:0] FLD_QTY    = 3'd5;
  localparam logic [2:0] FLD_CLIENT = 3'd6;
  localparam logic [2:0] FLD_EXTRA  = 3'd7;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UZ    = 8'd90;

  localparam int unsigned KW_MAX = 6;

  // keywords, right aligned, lower case
  localparam logic [47:0] KW_MARKET = 48'h6D61726B6574;
  localparam logic [47:0] KW_LIMIT  = 48'h006C696D6974;
  localparam logic [47:0] KW_CANCEL = 48'h63616E63656C;
  localparam logic [47:0] KW_MODIFY = 48'h6D6F64696679;
  localparam logic [47:0] KW_BUY    = 48'h000000627579;
  localparam logic [47:0] KW_B      = 48'h000000000062;
  localparam logic [47:0] KW_SELL   = 48'h000073656C6C;
  localparam logic [47:0] KW_S      = 48'h000000000073;

  localparam logic [67:0] LIM_U64  = {4'h0, 64'hFFFF_FFFF_FFFF_FFFF};
  localparam logic [67:0] LIM_SPOS = {4'h0, 64'h7FFF_FFFF_FFFF_FFFF};
  localparam logic [67:0] LIM_SNEG = {4'h0, 64'h8000_0000_0000_0000};

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction
endpackage
`default_nettype wire

### rtl/csv_order_line_parser_unit.sv
// A line's result is registered and shown in out_* in the cycle after its closing byte is accepted.
// Throughput: one byte per cycle while in_tready is high; the per-byte update (64-bit x10
// accumulate and range compare) and the field close both sit between state and result registers.
// in_tready drops only while a result waits in the output register and out_tready is low.
// Reset (rst_n low, synchronous): all line state cleared, no result pending, skip_header = 1.
// ----------------------------------------------------------------------------
// csv_order_line_parser_unit
// Byte-serial parser of comma-separated order lines, one order per line.
// ----------------------------------------------------------------------------
`default_nettype none
module csv_order_line_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data,      // skip_header
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,      // [7:0] char_byte
  input  wire logic         in_tlast,      // end_of_input
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [63:0] order_id, [127:64] time_stamp, [129:128] order_kind, [130] side_sell,
  // [194:131] price_value, [258:195] quantity_value, [322:259] client_id,
  // [323] has_client, [327:324] zero
  output logic [327:0]      out_tdata,
  output logic [2:0]        out_tuser      // [2:0] status
);

  // ---------------- state ----------------
  logic        skip_header_r;
  logic        header_pending_r;
  logic [2:0]  field_number_r;
  logic [63:0] acc_r;
  logic [1:0]  phase_r;
  logic        minus_r, ovf_r;
  logic [47:0] word_r;
  logic [2:0]  wlen_r;
  logic        spoiled_r, sat_r;
  logic        line_nonblank_r, fhb_r;
  logic [2:0]  err_r;
  logic [63:0] h_id_r, h_stamp_r, h_price_r, h_qty_r, h_client_r;
  logic [1:0]  h_kind_r;
  logic        h_side_r, h_cv_r;

  logic          out_valid_r;
  logic [327:0]  out_data_r;
  logic [2:0]    out_status_r;

  logic acc_in;
  logic [7:0] c;
  logic line_end, is_comma, sp;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign acc_in     = in_tvalid && in_tready;
  assign c          = in_tdata;
  assign is_comma   = (c == csvop_pkg::CH_COMMA);
  assign line_end   = in_tlast || (c == csvop_pkg::CH_NL);
  assign sp         = csvop_pkg::is_space(c);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // ---------------- field byte: number path ----------------
  logic        num_field, word_field, is_signed, is_digit;
  logic [67:0] lim, sum;
  logic [63:0] acc_b;
  logic [1:0]  phase_b;
  logic        minus_b, ovf_b;

  assign word_field = (field_number_r == csvop_pkg::FLD_TYPE) ||
                      (field_number_r == csvop_pkg::FLD_SIDE);
  assign num_field  = !word_field && (field_number_r != csvop_pkg::FLD_EXTRA);
  assign is_signed  = (field_number_r == csvop_pkg::FLD_PRICE);
  assign is_digit   = (c >= csvop_pkg::CH_ZERO) && (c <= csvop_pkg::CH_NINE);
  // acc*10 + digit, wide enough that the range check is a plain compare
  assign sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
               {64'd0, c[3:0] - csvop_pkg::CH_ZERO[3:0]};
  assign lim = !is_signed ? csvop_pkg::LIM_U64 :
               (minus_r ? csvop_pkg::LIM_SNEG : csvop_pkg::LIM_SPOS);

  always_comb begin
    acc_b = acc_r; phase_b = phase_r; minus_b = minus_r; ovf_b = ovf_r;
    if (phase_r != csvop_pkg::PH_STOP) begin
      if (sp) begin
        if (phase_r == csvop_pkg::PH_SIGN) begin
          ovf_b = 1'b1; phase_b = csvop_pkg::PH_STOP;
        end else if (phase_r == csvop_pkg::PH_DIGIT) begin
          phase_b = csvop_pkg::PH_STOP;
        end
      end else if (is_digit) begin
        if (sum > lim) begin
          ovf_b = 1'b1; phase_b = csvop_pkg::PH_STOP;
        end else begin
          acc_b = sum[63:0]; phase_b = csvop_pkg::PH_DIGIT;
        end
      end else if (phase_r == csvop_pkg::PH_DIGIT) begin
        phase_b = csvop_pkg::PH_STOP;
      end else if (phase_r == csvop_pkg::PH_START &&
                   (c == csvop_pkg::CH_PLUS || c == csvop_pkg::CH_MINUS)) begin
        if (c == csvop_pkg::CH_MINUS && !is_signed) begin
          ovf_b = 1'b1; phase_b = csvop_pkg::PH_STOP;
        end else begin
          minus_b = (c == csvop_pkg::CH_MINUS); phase_b = csvop_pkg::PH_SIGN;
        end
      end else begin
        ovf_b = 1'b1; phase_b = csvop_pkg::PH_STOP;
      end
    end
  end

  // ---------------- field byte: keyword path ----------------
  logic [47:0] word_b;
  logic [2:0]  wlen_b;
  logic        spoiled_b, sat_b;
  logic [7:0]  lc;

  assign lc = (c >= csvop_pkg::CH_UA && c <= csvop_pkg::CH_UZ) ? (c + 8'd32) : c;

  always_comb begin
    word_b = word_r; wlen_b = wlen_r; spoiled_b = spoiled_r; sat_b = sat_r;
    if (sp) begin
      if (wlen_r != 3'd0 || spoiled_r) sat_b = 1'b1;
    end else if (sat_r || wlen_r >= 3'(csvop_pkg::KW_MAX)) begin
      spoiled_b = 1'b1;
    end else begin
      word_b = {word_r[39:0], lc};
      wlen_b = wlen_r + 3'd1;
    end
  end

  // ---------------- operands of the field close ----------------
  // a comma or newline closes the field as it stands; any other last byte is taken in before the close
  logic        fb_num, fb_word;
  logic [63:0] f_acc;
  logic [1:0]  f_phase;
  logic        f_minus, f_ovf, f_spoiled;
  logic [47:0] f_word;
  logic [2:0]  f_wlen;

  assign fb_num  = !is_comma && !(c == csvop_pkg::CH_NL) && num_field;
  assign fb_word = !is_comma && !(c == csvop_pkg::CH_NL) && word_field;

  always_comb begin
    f_acc     = fb_num  ? acc_b     : acc_r;
    f_phase   = fb_num  ? phase_b   : phase_r;
    f_minus   = fb_num  ? minus_b   : minus_r;
    f_ovf     = fb_num  ? ovf_b     : ovf_r;
    f_word    = fb_word ? word_b    : word_r;
    f_wlen    = fb_word ? wlen_b    : wlen_r;
    f_spoiled = fb_word ? spoiled_b : spoiled_r;
  end

  function automatic logic word_is(input logic [47:0] w, input logic [2:0] n,
                                   input logic s, input logic [47:0] kw,
                                   input logic [2:0] kn);
    return !s && (n == kn) && (w == kw);
  endfunction

  logic        fhb_after, do_finish, num_good;
  logic [2:0]  err_f;
  logic [63:0] h_id_f, h_stamp_f, h_price_f, h_qty_f, h_client_f;
  logic [1:0]  h_kind_f;
  logic        h_side_f, h_cv_f;

  assign fhb_after = is_comma ? 1'b0 : ((c != csvop_pkg::CH_NL) ? 1'b1 : fhb_r);
  assign do_finish = is_comma || (line_end && fhb_after);
  assign num_good  = !f_ovf && f_phase[1];

  always_comb begin
    err_f = err_r;
    h_id_f = h_id_r; h_stamp_f = h_stamp_r; h_price_f = h_price_r;
    h_qty_f = h_qty_r; h_client_f = h_client_r; h_kind_f = h_kind_r;
    h_side_f = h_side_r; h_cv_f = h_cv_r;
    if (do_finish) begin
      case (field_number_r)
        csvop_pkg::FLD_ID: begin
          if (num_good) h_id_f = f_acc;
          else if (err_r == csvop_pkg::ST_OK) err_f = csvop_pkg::ST_BAD_NUM;
        end
        csvop_pkg::FLD_STAMP: begin
          if (num_good) h_stamp_f = f_acc;
          else if (err_r == csvop_pkg::ST_OK) err_f = csvop_pkg::ST_BAD_NUM;
        end
        csvop_pkg::FLD_TYPE: begin
          if (word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_MARKET, 3'd6))
            h_kind_f = csvop_pkg::KIND_MARKET;
          else if (word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_LIMIT, 3'd5))
            h_kind_f = csvop_pkg::KIND_LIMIT;
          else if (word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_CANCEL, 3'd6))
            h_kind_f = csvop_pkg::KIND_CANCEL;
          else if (word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_MODIFY, 3'd6))
            h_kind_f = csvop_pkg::KIND_MODIFY;
          else if (err_r == csvop_pkg::ST_OK) err_f = csvop_pkg::ST_BAD_TYPE;
        end
        csvop_pkg::FLD_SIDE: begin
          if (word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_BUY, 3'd3) ||
              word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_B, 3'd1))
            h_side_f = 1'b0;
          else if (word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_SELL, 3'd4) ||
                   word_is(f_word, f_wlen, f_spoiled, csvop_pkg::KW_S, 3'd1))
            h_side_f = 1'b1;
          else if (err_r == csvop_pkg::ST_OK) err_f = csvop_pkg::ST_BAD_SIDE;
        end
        csvop_pkg::FLD_PRICE: begin
          if (num_good) h_price_f = f_minus ? (64'd0 - f_acc) : f_acc;
          else if (err_r == csvop_pkg::ST_OK) err_f = csvop_pkg::ST_BAD_NUM;
        end
        csvop_pkg::FLD_QTY: begin
          if (num_good) h_qty_f = f_acc;
          else if (err_r == csvop_pkg::ST_OK) err_f = csvop_pkg::ST_BAD_NUM;
        end
        csvop_pkg::FLD_CLIENT: begin
          // an empty or all-blank client field means no client
          if (!(f_phase == csvop_pkg::PH_START && !f_ovf)) begin
            if (num_good) begin
              h_client_f = f_acc; h_cv_f = 1'b1;
            end else if (err_r == csvop_pkg::ST_OK) begin
              err_f = csvop_pkg::ST_BAD_NUM;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- line close ----------------
  // a comma that ends the line still opens the next field number
  logic       nonblank_after, skip, emit, ok;
  logic [2:0] fn_after;
  logic [3:0] count;
  logic [2:0] status;

  assign nonblank_after = line_nonblank_r || is_comma || !sp;
  assign fn_after = (is_comma && field_number_r != csvop_pkg::FLD_EXTRA) ?
                    (field_number_r + 3'd1) : field_number_r;
  assign count  = {1'b0, fn_after} + {3'b000, fhb_after};
  assign skip   = header_pending_r && skip_header_r;
  assign emit   = acc_in && line_end && !skip && nonblank_after;
  assign status = (count < 4'd6) ? csvop_pkg::ST_FEW : err_f;
  assign ok     = (status == csvop_pkg::ST_OK);

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_header_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      skip_header_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pending_r <= 1'b1;
      field_number_r <= '0; acc_r <= '0; phase_r <= csvop_pkg::PH_START;
      minus_r <= 1'b0; ovf_r <= 1'b0; word_r <= '0; wlen_r <= '0;
      spoiled_r <= 1'b0; sat_r <= 1'b0; line_nonblank_r <= 1'b0; fhb_r <= 1'b0;
      err_r <= csvop_pkg::ST_OK;
      h_id_r <= '0; h_stamp_r <= '0; h_price_r <= '0; h_qty_r <= '0;
      h_client_r <= '0; h_kind_r <= '0; h_side_r <= 1'b0; h_cv_r <= 1'b0;
    end else if (acc_in) begin
      if (line_end) begin
        header_pending_r <= in_tlast;
        field_number_r <= '0; acc_r <= '0; phase_r <= csvop_pkg::PH_START;
        minus_r <= 1'b0; ovf_r <= 1'b0; word_r <= '0; wlen_r <= '0;
        spoiled_r <= 1'b0; sat_r <= 1'b0; line_nonblank_r <= 1'b0; fhb_r <= 1'b0;
        err_r <= csvop_pkg::ST_OK;
        h_id_r <= '0; h_stamp_r <= '0; h_price_r <= '0; h_qty_r <= '0;
        h_client_r <= '0; h_kind_r <= '0; h_side_r <= 1'b0; h_cv_r <= 1'b0;
      end else begin
        err_r <= err_f;
        h_id_r <= h_id_f; h_stamp_r <= h_stamp_f; h_price_r <= h_price_f;
        h_qty_r <= h_qty_f; h_client_r <= h_client_f; h_kind_r <= h_kind_f;
        h_side_r <= h_side_f; h_cv_r <= h_cv_f;
        line_nonblank_r <= nonblank_after;
        fhb_r <= fhb_after;
        if (is_comma) begin
          field_number_r <= fn_after;
          acc_r <= '0; phase_r <= csvop_pkg::PH_START; minus_r <= 1'b0;
          ovf_r <= 1'b0; word_r <= '0; wlen_r <= '0; spoiled_r <= 1'b0;
          sat_r <= 1'b0;
        end else begin
          acc_r <= f_acc; phase_r <= f_phase; minus_r <= f_minus; ovf_r <= f_ovf;
          word_r <= f_word; wlen_r <= f_wlen; spoiled_r <= f_spoiled;
          sat_r <= fb_word ? sat_b : sat_r;
        end
      end
    end
  end

  // result register; a rejected line carries zero payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= status;
      out_data_r   <= ok ? {4'h0, h_cv_f, h_client_f, h_qty_f, h_price_f, h_side_f,
                            h_kind_f, h_stamp_f, h_id_f} : '0;
    end
  end

  // ---------------- assertions ----------------
`include "csv_order_line_parser_unit_macros.svh"
  `CSVOP_ASSERT_IMP(a_err_zero, out_tvalid && out_tuser != csvop_pkg::ST_OK, out_tdata == '0)
  `CSVOP_ASSERT_NXT(a_no_mid_line_out, acc_in && !line_end && !out_valid_r, !out_valid_r)
  `CSVOP_ASSERT_NXT(a_line_cleared, acc_in && line_end,
                    field_number_r == '0 && !line_nonblank_r && err_r == csvop_pkg::ST_OK)

endmodule
`default_nettype wire
